/* sv/aes_pkg.sv */
// Shared types for the ascending exchange sort block: cell links and control.
package aes_pkg;

  localparam int unsigned DataWidth = 32;

  typedef logic signed [DataWidth-1:0] sample_t;

  // What one cell shows its neighbors.
  typedef struct packed {
    sample_t value;
    logic    valid;
    logic    displaced;
  } cell_link_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic    insert;
    logic    shift_out;
    sample_t sample;
  } cell_ctl_t;

  typedef enum logic {
    ST_LOAD  = 1'b0,
    ST_DRAIN = 1'b1
  } sort_state_t;

endpackage

/* sv/ascending_exchange_sort.sv */
// Ascending exchange sort: a chain of CAPACITY insertion cells kept in sorted order.
// Load: one signed 32-bit sample is taken per cycle; every cell compares it with
// its own value at once and the larger values step one cell outward, so the
// chain is sorted after each beat. A sample that arrives while CAPACITY values
// are held is dropped and the run is marked overflowed. The beat with tlast
// starts the drain in the next cycle: the head cell drives the result, and each
// accepted result shifts the whole chain one cell toward the head, so a run of
// N values leaves in N beats at up to one per cycle, the last beat carrying
// tlast and every beat carrying the overflow flag in tuser. No input is taken
// while a run drains (s_axis_tready low); afterwards the chain is empty and
// loading resumes. No clearing pass is needed after reset.
module ascending_exchange_sort #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [31:0]              s_axis_tdata,   // [31:0] sample_value
  input  logic                     s_axis_tlast,   // end_of_set
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [31:0]              m_axis_tdata,   // [31:0] sorted_value
  output logic                     m_axis_tlast,   // final_result
  output logic                     m_axis_tuser    // [0] overflowed
);
  import aes_pkg::*;

  localparam int unsigned CountWidth = $clog2(CAPACITY + 1);

  sort_state_t            state, state_next;
  logic [CountWidth-1:0]  count, count_next;
  logic                   dropped, dropped_next;
  logic                   full;
  logic                   in_beat;
  logic                   out_beat;
  cell_ctl_t              ctl;
  cell_link_t             links [CAPACITY];

  assign full     = (count == CountWidth'(CAPACITY));
  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_beat = m_axis_tvalid && m_axis_tready;

  // Broadcast control: insert only when there is room, shift on each result beat.
  assign ctl = '{insert: in_beat && !full, shift_out: out_beat,
                 sample: sample_t'(s_axis_tdata)};

  // The chain: cell 0 is the head (smallest value).
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_link_t left_in;
    cell_link_t right_in;

    if (i == 0) begin : g_head
      assign left_in = '{value: '0, valid: 1'b1, displaced: 1'b0};
    end else begin : g_body
      assign left_in = links[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_in = '{value: '0, valid: 1'b0, displaced: 1'b0};
    end else begin : g_inner
      assign right_in = links[i+1];
    end

    aes_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctl   (ctl),
      .left  (left_in),
      .right (right_in),
      .link  (links[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      count   <= '0;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      dropped <= dropped_next;
    end
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    dropped_next = dropped;
    unique case (state)
      ST_LOAD: begin
        if (in_beat) begin
          if (full) begin
            dropped_next = 1'b1;
          end else begin
            count_next = count + 1'b1;
          end
          if (s_axis_tlast) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_beat) begin
          count_next = count - 1'b1;
          // Last value gone: drop the overflow mark and resume loading.
          if (count == CountWidth'(1)) begin
            state_next   = ST_LOAD;
            dropped_next = 1'b0;
          end
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  assign s_axis_tready = (state == ST_LOAD);
  assign m_axis_tvalid = (state == ST_DRAIN);
  assign m_axis_tdata  = links[0].value;
  assign m_axis_tlast  = (count == CountWidth'(1));
  assign m_axis_tuser  = dropped;

endmodule

/* sv/aes_cell.sv */
// One sorting cell: holds a value, inserts in order, shifts toward the head on drain.
module aes_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  aes_pkg::cell_ctl_t    ctl,
  input  aes_pkg::cell_link_t   left,
  input  aes_pkg::cell_link_t   right,
  output aes_pkg::cell_link_t   link
);
  import aes_pkg::*;

  sample_t value;
  logic    valid;
  logic    displaced;

  // Larger than the new sample: this value moves one cell outward.
  assign displaced = valid && (ctl.sample < value);

  always_ff @(posedge clk) begin
    if (ctl.shift_out) begin
      value <= right.value;
    end else if (ctl.insert) begin
      if (left.displaced) begin
        value <= left.value;
      end else if ((displaced || !valid) && left.valid) begin
        value <= ctl.sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.shift_out) begin
      valid <= right.valid;
    end else if (ctl.insert && left.valid) begin
      valid <= 1'b1;
    end
  end

  assign link = '{value: value, valid: valid, displaced: displaced};

endmodule

/* sv/aes_check.sv */
// Port-level checks for the ascending exchange sort block, bound to the top level.
module aes_check (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);

  // Loading and draining never overlap.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while results are pending");

  // A closing input beat opens a drain in the next cycle.
  a_drain_starts: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> m_axis_tvalid)
    else $error("no result after the last input beat");

  // The final result beat ends the run and reopens the input.
  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid && s_axis_tready)
    else $error("run did not end after its final beat");

  // The overflow mark is the same on every beat of a run.
  a_flag_steady: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && $past(m_axis_tvalid) |-> m_axis_tuser == $past(m_axis_tuser))
    else $error("overflow mark changed inside a run");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

endmodule

bind ascending_exchange_sort aes_check u_aes_check (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

/* bench/ascending_exchange_sort_test.sv */
// Self-checking bench for the ascending exchange sort block: random sets, sorted-order check.
module ascending_exchange_sort_test;
  timeunit 1ns;
  timeprecision 1ps;

  import aes_pkg::*;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned ItemsPerPhase = 112;
  localparam int unsigned CycleLimit = 400000;
  // Longest a full chain can take to empty, plus margin.
  localparam int unsigned DrainSlack = 2 * CAPACITY + 20;
  localparam sample_t SampleMin = {1'b1, {31{1'b0}}};
  localparam sample_t SampleMax = {1'b0, {31{1'b1}}};

  typedef struct {
    sample_t value;
    logic    closes_set;
  } sample_beat_t;

  typedef struct {
    sample_t value;
    logic    is_last;
    logic    ovf;
  } sorted_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [31:0] sample_value
  logic        s_axis_tlast = 1'b0; // end_of_set
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [31:0] sorted_value
  logic        m_axis_tlast;        // final_result
  logic        m_axis_tuser;        // [0] overflowed

  // Stimulus waiting to be driven, and the predictor's view of the chain.
  sample_beat_t pending_samples[$];
  sample_t      held_sorted[$];
  logic         run_overflowed = 1'b0;
  sorted_beat_t expected_sorted[$];

  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  ascending_exchange_sort #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Place one accepted sample into the predicted chain; on the closing beat
  // queue the whole chain, smallest first, and empty it. Equal values are
  // indistinguishable, so their relative order needs no tracking.
  function automatic void place_sample(sample_t value, logic closes_set);
    int pos;
    pos = 0;
    if (held_sorted.size() < CAPACITY) begin
      while (pos < held_sorted.size() && held_sorted[pos] <= value) pos++;
      held_sorted.insert(pos, value);
    end else begin
      // Full chain: drop the sample, flag the whole run.
      run_overflowed = 1'b1;
    end
    if (closes_set) begin
      foreach (held_sorted[i]) begin
        expected_sorted.push_back('{value:   held_sorted[i],
                                    is_last: (i == held_sorted.size() - 1),
                                    ovf:     run_overflowed});
      end
      held_sorted.delete();
      run_overflowed = 1'b0;
    end
  endfunction

  function automatic void push_sample(sample_t value, logic closes_set);
    pending_samples.push_back('{value: value, closes_set: closes_set});
  endfunction

  // Mix of full-range values, a narrow band that forces duplicates, and extremes.
  function automatic sample_t draw_sample();
    sample_t value;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: value = SampleMin;
          1: value = SampleMax;
          2: value = '0;
          default: value = '1;
        endcase
      end
      1, 2, 3: value = sample_t'(int'($urandom_range(15)) - 8);
      default: value = sample_t'($urandom);
    endcase
    return value;
  endfunction

  function automatic void queue_random_set(int unsigned set_size);
    for (int unsigned i = 0; i < set_size; i++) push_sample(draw_sample(), i == set_size - 1);
  endfunction

  // Driver: advance to the next sample only once the current beat is taken.
  always @(posedge clk) begin : feed_samples
    sample_beat_t beat;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_samples.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        beat = pending_samples.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= beat.value;
        s_axis_tlast  <= beat.closes_set;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Monitor: check result beats against the oldest prediction, then feed
  // accepted input beats to the predictor. A result can never belong to an
  // input taken at the same edge, so checking first is safe.
  always @(posedge clk) begin : watch_beats
    sorted_beat_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_sorted.size() == 0) begin
          $error("sorted_value %0d arrived with no value pending", $signed(m_axis_tdata));
          mismatches++;
        end else begin
          want = expected_sorted.pop_front();
          if (m_axis_tdata !== want.value) begin
            $error("sorted_value: expected %0d, got %0d", want.value, $signed(m_axis_tdata));
            mismatches++;
          end
          if (m_axis_tlast !== want.is_last) begin
            $error("final_result: expected %0b, got %0b", want.is_last, m_axis_tlast);
            mismatches++;
          end
          if (m_axis_tuser !== want.ovf) begin
            $error("overflowed: expected %0b, got %0b", want.ovf, m_axis_tuser);
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) place_sample(s_axis_tdata, s_axis_tlast);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Stimulus; all queue and knob updates happen on the falling edge so the
  // clocked blocks never race with them.
  initial begin : stimulus
    int unsigned phase_items;
    int unsigned set_size;
    rst = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 4; phase++) begin
      @(negedge clk);
      case (phase)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 55;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 55;
        end
        default: begin
          sender_idle_pct    = 16;
          receiver_stall_pct = 16;
        end
      endcase

      if (phase == 0) begin
        // Extremes mixed with zero and the values next to it, minimum and maximum twice each.
        push_sample(SampleMax, 1'b0);
        push_sample(SampleMin, 1'b0);
        push_sample('0, 1'b0);
        push_sample('1, 1'b0);
        push_sample(sample_t'(1), 1'b0);
        push_sample(SampleMin, 1'b0);
        push_sample(SampleMax, 1'b1);
        // Single-value set.
        push_sample(sample_t'(5), 1'b1);
        // All equal.
        repeat (3) push_sample(sample_t'(-3), 1'b0);
        push_sample(sample_t'(-3), 1'b1);
        // Strictly descending arrival.
        push_sample(sample_t'(40), 1'b0);
        push_sample(sample_t'(30), 1'b0);
        push_sample(sample_t'(20), 1'b0);
        push_sample(sample_t'(10), 1'b1);
      end

      // Open each phase at the capacity edge: exactly full, then one over
      // (closing sample dropped), then further over.
      phase_items = 64 + phase;
      queue_random_set(64 + phase);
      while (phase_items < ItemsPerPhase) begin
        case ($urandom_range(19))
          0: set_size = $urandom_range(72, 60);
          1, 2, 3, 4: set_size = $urandom_range(40, 13);
          default: set_size = $urandom_range(12, 1);
        endcase
        queue_random_set(set_size);
        phase_items += set_size;
      end

      // Hold until every sample is taken and every sorted value returned.
      while (pending_samples.size() != 0 || s_axis_tvalid || expected_sorted.size() != 0)
        @(negedge clk);
    end

    repeat (DrainSlack) @(negedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
